// ===== rtl/soah_pkg.sv =====
package soah_pkg;

    localparam int unsigned HEAP_DEPTH_DEF = 64;
    localparam logic [15:0] CAPACITY_RESET = 16'd4;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CAPACITY = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_ORDER    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_POP_TOP,
        ST_SIFT_RDL,
        ST_SIFT_RDR,
        ST_SIFT_CMP,
        ST_ADMIT,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_FINISH
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic set_order_fail;
        logic pop_release;
        logic pop_top_rd;
        logic pop_top_wr;
        logic park;
        logic sift_rd_left;
        logic sift_rd_right;
        logic sift_step;
        logic admit;
        logic push_rd_parent;
        logic push_step;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic failed;
        logic order_bad;
        logic top_releasable;
        logic have_left;
        logic sift_swap;
        logic fits;
        logic heap_full;
        logic push_at_root;
        logic push_swap;
    } dp_status_t;

endpackage

// ===== rtl/soah_ram.sv =====
module soah_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/soah_ctrl.sv =====
module soah_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output soah_pkg::ctrl_cmd_t   cmd,
    input  soah_pkg::dp_status_t  stat
);
    import soah_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.failed)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.order_bad)
                begin
                    cmd.set_order_fail = 1'b1;
                    state_next         = ST_FINISH;
                end
                else
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                // Root word is valid in the cached root register.
                if (stat.top_releasable)
                begin
                    cmd.pop_release = 1'b1;
                    state_next      = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_ADMIT;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop_top_rd = 1'b1;
                state_next     = ST_POP_TOP;
            end
            ST_POP_TOP:
            begin
                cmd.pop_top_wr = 1'b1;
                state_next     = ST_SIFT_RDL;
            end
            ST_SIFT_RDL:
            begin
                // The sinking entry is parked at its current slot each level.
                cmd.park = 1'b1;
                if (stat.have_left)
                begin
                    cmd.sift_rd_left = 1'b1;
                    state_next       = ST_SIFT_RDR;
                end
                else
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_SIFT_RDR:
            begin
                cmd.sift_rd_right = 1'b1;
                state_next        = ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                cmd.sift_step = 1'b1;
                state_next    = stat.sift_swap ? ST_SIFT_RDL : ST_POP_WAIT;
            end
            ST_ADMIT:
            begin
                cmd.admit = 1'b1;
                if (stat.fits && !stat.heap_full)
                begin
                    state_next = ST_PUSH_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PUSH_RD:
            begin
                // The rising entry is parked at its current slot each level.
                cmd.park = 1'b1;
                if (stat.push_at_root)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.push_rd_parent = 1'b1;
                    state_next         = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP:
            begin
                cmd.push_step = 1'b1;
                state_next    = stat.push_swap ? ST_PUSH_RD : ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A result strobe always closes a transaction that was started.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a transaction");
    // Start is only taken from idle.
    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == ST_IDLE))
        else $error("capture outside idle");
    // After a result the block is ready again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not idle after result");
`endif
endmodule

// ===== rtl/soah_dp.sv =====
module soah_dp #(
    parameter int unsigned HEAP_DEPTH = soah_pkg::HEAP_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_data,
    input  logic [15:0]           group_seats,
    input  logic [15:0]           pickup_position,
    input  logic [15:0]           dropoff_position,
    input  logic                  last_trip,
    input  soah_pkg::ctrl_cmd_t   cmd,
    output soah_pkg::dp_status_t  stat,
    output logic [1:0]            status,
    output logic [15:0]           seats_in_use,
    output logic                  list_done
);
    import soah_pkg::*;

    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

    logic [15:0]   cap_reg;
    logic [CW-1:0] count_reg;
    logic [15:0]   taken_reg;
    logic [1:0]    fail_reg;
    logic [15:0]   lastpick_reg;
    logic [15:0]   seats_reg;
    logic [15:0]   pick_reg;
    logic [15:0]   drop_reg;
    logic          last_reg;
    logic [31:0]   root_reg;
    logic [31:0]   cur_reg;
    logic [31:0]   left_reg;
    logic [AW-1:0] pos_reg;
    logic [1:0]    status_reg;
    logic [15:0]   seats_out_reg;
    logic          done_out_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;

    soah_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Child and parent index arithmetic on positions, child choice and seat sum.
    logic [CW:0]   left_idx;
    logic [CW:0]   right_idx;
    logic [AW-1:0] parent_idx;
    logic          right_ok;
    logic          pick_right;
    logic [31:0]   child;
    logic [AW-1:0] child_idx;
    logic [16:0]   sum;

    always_comb
    begin
        left_idx   = ({{(CW+1-AW){1'b0}}, pos_reg} << 1) | {{CW{1'b0}}, 1'b1};
        right_idx  = left_idx + 1'b1;
        parent_idx = AW'(({1'b0, pos_reg} - 1'b1) >> 1);
        right_ok   = right_idx < {1'b0, count_reg};
        pick_right = right_ok && (rdata[31:16] < left_reg[31:16]);
        child      = pick_right ? rdata : left_reg;
        child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
        sum        = {1'b0, seats_reg} + {1'b0, taken_reg};
    end

    // Status to the controller.
    always_comb
    begin
        stat                = '0;
        stat.failed         = (fail_reg != STATUS_OK);
        stat.order_bad      = pick_reg < lastpick_reg;
        stat.top_releasable = (count_reg != '0) && (root_reg[31:16] <= pick_reg);
        stat.have_left      = left_idx < {1'b0, count_reg};
        stat.sift_swap      = cur_reg[31:16] > child[31:16];
        stat.fits           = sum <= {1'b0, cap_reg};
        stat.heap_full      = count_reg >= CW'(HEAP_DEPTH);
        stat.push_at_root   = (pos_reg == '0);
        stat.push_swap      = rdata[31:16] > cur_reg[31:16];
    end

    // Memory port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = cur_reg;
        raddr = '0;
        if (cmd.pop_top_rd)
        begin
            // The count is already reduced, so it indexes the last entry.
            raddr = count_reg[AW-1:0];
        end
        if (cmd.pop_top_wr)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = rdata;
        end
        if (cmd.park)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = cur_reg;
        end
        if (cmd.sift_rd_left)
        begin
            raddr = left_idx[AW-1:0];
        end
        if (cmd.sift_rd_right)
        begin
            raddr = right_idx[AW-1:0];
        end
        if (cmd.sift_step)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = stat.sift_swap ? child : cur_reg;
        end
        if (cmd.admit)
        begin
            we    = stat.fits && !stat.heap_full;
            waddr = count_reg[AW-1:0];
            wdata = {drop_reg, seats_reg};
        end
        if (cmd.push_rd_parent)
        begin
            raddr = parent_idx;
        end
        if (cmd.push_step)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = stat.push_swap ? rdata : cur_reg;
        end
    end

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // List state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            taken_reg    <= '0;
            fail_reg     <= STATUS_OK;
            lastpick_reg <= '0;
            root_reg     <= '0;
            status_reg   <= STATUS_OK;
            done_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_order_fail)
            begin
                fail_reg <= STATUS_ORDER;
            end
            if (cmd.capture && (fail_reg == STATUS_OK) && !(pickup_position < lastpick_reg))
            begin
                lastpick_reg <= pickup_position;
            end
            if (cmd.pop_release)
            begin
                taken_reg <= (root_reg[15:0] <= taken_reg) ? taken_reg - root_reg[15:0] : '0;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.pop_top_wr)
            begin
                root_reg <= rdata;
            end
            if (cmd.sift_step && stat.sift_swap && pos_reg == '0)
            begin
                root_reg <= child;
            end
            if (cmd.admit)
            begin
                if (!stat.fits)
                begin
                    fail_reg <= STATUS_CAPACITY;
                end
                else if (stat.heap_full)
                begin
                    fail_reg <= STATUS_FULL;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    taken_reg <= sum[15:0];
                    if (count_reg == '0)
                    begin
                        root_reg <= {drop_reg, seats_reg};
                    end
                end
            end
            if (cmd.push_step && stat.push_swap && parent_idx == '0)
            begin
                root_reg <= cur_reg;
            end
            if (cmd.finish)
            begin
                status_reg   <= fail_reg;
                done_out_reg <= last_reg;
                if (last_reg)
                begin
                    count_reg    <= '0;
                    taken_reg    <= '0;
                    fail_reg     <= STATUS_OK;
                    lastpick_reg <= '0;
                end
            end
        end
    end

    // Transaction payload and walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seats_reg <= group_seats;
            pick_reg  <= pickup_position;
            drop_reg  <= dropoff_position;
            last_reg  <= last_trip;
        end
        if (cmd.pop_top_wr)
        begin
            cur_reg <= rdata;
            pos_reg <= '0;
        end
        if (cmd.sift_rd_right)
        begin
            left_reg <= rdata;
        end
        if (cmd.sift_step && stat.sift_swap)
        begin
            pos_reg <= child_idx;
        end
        if (cmd.admit)
        begin
            cur_reg <= {drop_reg, seats_reg};
            pos_reg <= count_reg[AW-1:0];
        end
        if (cmd.push_step && stat.push_swap)
        begin
            pos_reg <= parent_idx;
        end
        if (cmd.finish)
        begin
            seats_out_reg <= taken_reg;
        end
    end

    assign status       = status_reg;
    assign seats_in_use = seats_out_reg;
    assign list_done    = done_out_reg;

`ifndef NO_ASSERTIONS
    // The heap never holds more entries than its depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("heap count beyond depth");
    // Releasing needs an entry to release.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_release |-> (count_reg != '0))
        else $error("release from empty heap");
    // A push writes only below the depth.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.admit && we) |-> (count_reg < CW'(HEAP_DEPTH)))
        else $error("push into full heap");
`endif
endmodule

// ===== rtl/seat_occupancy_admission_heap.sv =====
// Reservation admission with a drop-off-ordered min-heap in one RAM. Pulse
// start while busy is low; one result follows with done high for a single
// cycle, in the cycle that busy falls, and it cannot be stalled. While busy,
// the block releases each group whose drop-off is at or before the pickup,
// sinking the moved entry down the heap, then admits and pushes the new
// group up the heap; a list that has failed goes straight to its result. All
// heap steps go through the single RAM port pair with its registered read.
module seat_occupancy_admission_heap #(
    parameter int unsigned HEAP_DEPTH = soah_pkg::HEAP_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] group_seats,
    input  logic [15:0] pickup_position,
    input  logic [15:0] dropoff_position,
    input  logic        last_trip,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] seats_in_use,
    output logic        list_done
);
    import soah_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    logic       done_int;
    logic       done_reg;

    soah_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done_int),
        .cmd   (cmd),
        .stat  (stat)
    );

    soah_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .group_seats      (group_seats),
        .pickup_position  (pickup_position),
        .dropoff_position (dropoff_position),
        .last_trip        (last_trip),
        .cmd              (cmd),
        .stat             (stat),
        .status           (status),
        .seats_in_use     (seats_in_use),
        .list_done        (list_done)
    );

    // Result strobe lines up with the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_int;
        end
    end

    assign done = done_reg;
endmodule
